// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the distance transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SDT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance transform package
// Item types, queue entry, status groups and sequencer states.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int SAMPLE_W = 20;
  localparam int DIST_W   = 20;
  localparam int POS_W    = 6;
  localparam int DEN_W    = 8;

  // Item on the sample channel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_sq;
    logic                last;
  } sample_item_t;

  // Item on the result channel.
  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic              last_res;
  } result_item_t;

  // Classified sample as it waits between front and back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos;
    logic                line_end;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic scanning;
  } back_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_MUL,
    BK_DECIDE,
    SC_START,
    SC_LOAD,
    SC_CHECK,
    SC_CMP,
    SC_EMIT
  } back_state_t;

endpackage

// ===== rtl/core/sdt_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one item of a given type.
// ----------------------------------------------------------------------------
interface sdt_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sdt_front.sv =====
// ----------------------------------------------------------------------------
// Distance transform front end
// Accepts samples, numbers them within the line and marks the line end.
// ----------------------------------------------------------------------------
module sdt_front import sdt_pkg::*; #(
  parameter int LINE_LENGTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  sdt_stream_if.sink    samples,
  input  fifo_stat_t    q_stat,
  output logic          q_push,
  output queue_item_t   q_data
);

  localparam int AW = $clog2(LINE_LENGTH);

  logic [AW-1:0] load_pos;
  logic          at_end;

  // An item is taken whenever the queue has room.
  assign samples.ready = !q_stat.full;
  assign q_push        = samples.valid && samples.ready;
  assign at_end        = (load_pos == AW'(LINE_LENGTH - 1));

  // A full line ends just as a marked one does.
  always_comb begin
    q_data.sample   = samples.payload.sample_sq;
    q_data.pos      = POS_W'(load_pos);
    q_data.line_end = samples.payload.last || at_end;
  end

  // Position counter within the current line.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
    end else if (q_push) begin
      if (q_data.line_end) begin
        load_pos <= '0;
      end else begin
        load_pos <= load_pos + AW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sdt_fifo.sv =====
// ----------------------------------------------------------------------------
// Distance transform queue
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module sdt_fifo import sdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_data,
  input  logic        pop,
  output queue_item_t pop_data,
  output fifo_stat_t  stat
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  queue_item_t       entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign stat.full  = (count == (PW+1)'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sdt_back.sv =====
// ----------------------------------------------------------------------------
// Distance transform back end
// Builds the lower envelope of parabolas and scans it to emit results.
// ----------------------------------------------------------------------------
module sdt_back import sdt_pkg::*; #(
  parameter int LINE_LENGTH = 64,
  parameter int VALUE_BITS  = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_item_t   q_data,
  input  fifo_stat_t    q_stat,
  output logic          q_pop,
  sdt_stream_if.source  results,
  output back_stat_t    stat
);

  localparam int AW     = $clog2(LINE_LENGTH);
  localparam int HW     = ((VALUE_BITS > 12) ? VALUE_BITS : 12) + 1;
  localparam int NUM_W  = HW + 1;
  localparam int PROD_W = NUM_W + DEN_W + 1;
  localparam int SW     = ((VALUE_BITS > 2 * AW) ? VALUE_BITS : 2 * AW) + 1;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  // One envelope entry: vertex, its sample and its left boundary.
  typedef struct packed {
    logic [AW-1:0]           v;
    logic [VALUE_BITS-1:0]   f;
    logic signed [NUM_W-1:0] bnum;
    logic [DEN_W-1:0]        bden;
  } env_entry_t;

  env_entry_t env_mem [LINE_LENGTH];
  env_entry_t rd_data;
  env_entry_t mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;

  back_state_t state;
  back_state_t state_next;

  logic [AW-1:0]           k;
  logic [AW-1:0]           top;
  logic [VALUE_BITS-1:0]   in_f;
  logic [AW-1:0]           in_q;
  logic                    in_end;
  logic [HW-1:0]           hq;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] bnum_k;
  logic [DEN_W-1:0]        bden_k;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic [AW-1:0]           i;
  logic [AW-1:0]           last_i;
  logic [AW-1:0]           cur_v;
  logic [VALUE_BITS-1:0]   cur_f;
  logic                    out_valid;
  result_item_t            out_data;

  logic [AW-1:0]           pop_pos;
  logic [VALUE_BITS-1:0]   pop_f;
  logic [HW-1:0]           hv;
  logic [NUM_W-1:0]        scan_rhs;
  logic                    scan_step;
  logic                    pop_ok;
  logic                    out_free;
  logic                    emit;
  logic [AW-1:0]           gap;
  logic [SW-1:0]           val;
  logic [VALUE_BITS-1:0]   val_sat;

  assign results.valid   = out_valid;
  assign results.payload = out_data;
  assign out_free        = !out_valid || results.ready;

  assign pop_pos   = AW'(q_data.pos);
  assign pop_f     = VALUE_BITS'(q_data.sample);
  assign hv        = HW'(rd_data.f) + HW'(rd_data.v) * HW'(rd_data.v);
  assign scan_rhs  = NUM_W'(i) * NUM_W'(rd_data.bden);
  assign scan_step = ($signed(rd_data.bnum) < $signed(scan_rhs));
  assign pop_ok    = (k != '0) && (prod_l <= prod_r);

  // Distance to the current vertex, squared, plus its sample, saturated.
  assign gap     = (i >= cur_v) ? (i - cur_v) : (cur_v - i);
  assign val     = SW'(cur_f) + SW'(gap) * SW'(gap);
  assign val_sat = (val > SW'(VALUE_MAX)) ? VALUE_MAX : val[VALUE_BITS-1:0];

  assign stat.busy     = (state != BK_IDLE);
  assign stat.scanning = (state == SC_START) || (state == SC_LOAD) ||
                         (state == SC_CHECK) || (state == SC_CMP) ||
                         (state == SC_EMIT);

  // Envelope memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      env_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= env_mem[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) state_next = BK_READ;
      end
      BK_READ: begin
        if (in_q != '0)  state_next = BK_CALC;
        else if (in_end) state_next = SC_START;
        else             state_next = BK_IDLE;
      end
      BK_CALC: state_next = BK_MUL;
      BK_MUL:  state_next = BK_DECIDE;
      BK_DECIDE: begin
        if (pop_ok)      state_next = BK_READ;
        else if (in_end) state_next = SC_START;
        else             state_next = BK_IDLE;
      end
      SC_START: state_next = SC_LOAD;
      SC_LOAD:  state_next = SC_CHECK;
      SC_CHECK: begin
        if (k < top) state_next = SC_CMP;
        else         state_next = SC_EMIT;
      end
      SC_CMP: begin
        if (scan_step) state_next = SC_CHECK;
        else           state_next = SC_EMIT;
      end
      SC_EMIT: begin
        if (out_free) begin
          if (i == last_i) state_next = BK_IDLE;
          else             state_next = SC_CHECK;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Memory port and handshake controls.
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = k + AW'(1);
    mem_raddr = k;
    mem_wdata = '{v: in_q, f: in_f, bnum: num, bden: den};
    emit      = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = !q_stat.empty;
      BK_READ: begin
        if (in_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '{v: '0, f: in_f, bnum: '0, bden: '0};
        end
      end
      BK_DECIDE: mem_we = !pop_ok;
      SC_START:  mem_raddr = '0;
      SC_CHECK:  mem_raddr = k + AW'(1);
      SC_EMIT:   emit = out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Envelope top pointer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == BK_READ && in_q == '0) begin
        top <= '0;
      end else if (state == BK_DECIDE && !pop_ok) begin
        top <= k + AW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      in_f   <= pop_f;
      in_q   <= pop_pos;
      in_end <= q_data.line_end;
      hq     <= HW'(pop_f) + HW'(pop_pos) * HW'(pop_pos);
      k      <= top;
    end
    if (state == BK_CALC) begin
      num    <= $signed({1'b0, hq}) - $signed({1'b0, hv});
      den    <= DEN_W'({in_q - rd_data.v, 1'b0});
      bnum_k <= rd_data.bnum;
      bden_k <= rd_data.bden;
    end
    if (state == BK_MUL) begin
      prod_l <= PROD_W'(num) * PROD_W'($signed({1'b0, bden_k}));
      prod_r <= PROD_W'(bnum_k) * PROD_W'($signed({1'b0, den}));
    end
    if (state == BK_DECIDE && pop_ok) begin
      k <= k - AW'(1);
    end
    if (state == SC_START) begin
      k      <= '0;
      i      <= '0;
      last_i <= in_q;
    end
    if (state == SC_LOAD) begin
      cur_v <= rd_data.v;
      cur_f <= rd_data.f;
    end
    if (state == SC_CMP && scan_step) begin
      k     <= k + AW'(1);
      cur_v <= rd_data.v;
      cur_f <= rd_data.f;
    end
    if (emit) begin
      out_data.dist_sq  <= DIST_W'(val_sat);
      out_data.last_res <= (i == last_i);
      i                 <= i + AW'(1);
    end
  end

endmodule

// ===== rtl/core/squared_distance_transform_1d_unit.sv =====
// ----------------------------------------------------------------------------
// One-dimensional squared distance transform
// Lower envelope of parabolas over one line, exact fractional boundaries.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the sample channel, one item per position, the
// final one of a line marked by last; a line that reaches LINE_LENGTH
// positions ends there on its own. Results leave on the result channel, one
// item per position in order, all of them after the final sample, and the
// final result carries last_res. A sample that does not end a line gives no
// result.
// Sequencing: each sample passes the envelope sequencer states BK_IDLE,
// BK_READ, BK_CALC, BK_MUL and BK_DECIDE (the first of a line only BK_IDLE
// and BK_READ), and every parabola it removes repeats the read, subtract,
// multiply and compare steps on the envelope memory. The scan starts with
// SC_START and SC_LOAD, then passes SC_CHECK, SC_CMP (while entries remain)
// and SC_EMIT for each result, plus SC_CMP and SC_CHECK per envelope step.
// A two-item queue lets the sample channel keep accepting while the
// envelope is worked on. A stalled receiver holds the output register and
// stops the scan; once the queue fills, samples are refused.
// Reset clears control state only; the envelope memory needs no clearing.
// ----------------------------------------------------------------------------
module squared_distance_transform_1d_unit import sdt_pkg::*; #(
  parameter int LINE_LENGTH = 64,
  parameter int VALUE_BITS  = 20
) (
  input  logic          clk,
  input  logic          rst,
  sdt_stream_if.sink    samples,
  sdt_stream_if.source  results
);

  logic        q_push;
  logic        q_pop;
  queue_item_t q_in;
  queue_item_t q_out;
  fifo_stat_t  q_stat;
  back_stat_t  b_stat;

  // Intake and classification.
  sdt_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  // Queue between the two halves.
  sdt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Envelope build and result scan.
  sdt_back #(
    .LINE_LENGTH(LINE_LENGTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_out),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .results (results),
    .stat    (b_stat)
  );

  `include "assert_macros.svh"

  // Checks on queue traffic against the back end sequencer.
  `SDT_ASSERT_IMP(a_no_push_when_full, clk, rst, q_push, !q_stat.full, "push into full queue")
  `SDT_ASSERT_IMP(a_no_pop_in_scan, clk, rst, b_stat.scanning, !q_pop, "queue popped during scan")
  `SDT_ASSERT_NXT(a_busy_after_pop, clk, rst, q_pop, b_stat.busy, "back end idle after pop")

endmodule
